FILE: hw/rtl/clbe_pkg.sv
// Shared constants and codes for the cell list binning engine.
// No dependencies.
`default_nettype none
package clbe_pkg;
	localparam int MAX_SIDE   = 16;
	localparam int SIDE_W     = 5;                 // holds MAX_SIDE
	localparam int IDX_W      = 4;                 // axis index 0..MAX_SIDE-1
	localparam int NUM_CELLS  = MAX_SIDE * MAX_SIDE * MAX_SIDE;
	localparam int CELL_W     = 12;
	localparam int CAP        = 8;
	localparam int CAP_W      = 3;
	localparam int CNT_W      = 4;
	localparam int ID_W       = 10;
	localparam int POS_W      = 16;
	localparam int CODE_W     = 5;
	localparam int LAST_CODE  = 26;
	localparam logic [POS_W:0] ONE_FIXED = 17'd16384;

	typedef enum logic [1:0] {
		FN_CLEAR  = 2'd0,
		FN_INSERT = 2'd1,
		FN_QUERY  = 2'd2,
		FN_READ   = 2'd3
	} func_t;

	localparam logic REG_CELL_SIZE = 1'b0;
	localparam logic REG_SIDE      = 1'b1;
endpackage
`default_nettype wire

FILE: hw/rtl/cell_list_binning_engine_core.sv
// Cell list binning engine: uniform 3D grid with per-cell point slots.
// Uses clbe_pkg for constants and function codes.
//
// Input channel (in_valid/in_ready) takes one command per transfer: clear, insert,
// neighbour query or slot read. Results leave on out_valid/out_ready through an
// output register; every command gives one result except a neighbour query,
// which gives one per in-range cell of the 27-cell block, last marking the end.
// One command is worked at a time; in_ready is high only while idle.
// Steps per command (a result held up by the receiver waits in S_EMIT):
//   insert: per axis the shared divider subtracts, quotient capped at
//           cells_per_side-1; then the index is formed and the cell updated;
//   query : bit-serial division splits cell_sel into three axis indices, then
//           S_NCHK skips out-of-range codes, each neighbour runs S_MUL1 to S_EMIT;
//   read  : S_RDCNT, S_USE read count and slot;  clear: one count entry per cycle.
// After reset the same clear sweep zeroes the count memory while in_ready
// stays low; configuration writes are taken at any time.
// A stalled receiver holds the result in the output register and the
// sequencer waits before writing the next one.
`default_nettype none
module cell_list_binning_engine_core (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [2:0]                   paddr,
	input  wire logic [31:0]                  pwdata,
	output logic      [31:0]                  prdata,
	output logic                              pready,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [1:0]                   func,
	input  wire logic signed [15:0]           pos_x,
	input  wire logic signed [15:0]           pos_y,
	input  wire logic signed [15:0]           pos_z,
	input  wire logic [9:0]                   point_id,
	input  wire logic [11:0]                  cell_sel,
	input  wire logic [2:0]                   slot_sel,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [11:0]                       cell_out,
	output logic [3:0]                        count_out,
	output logic [9:0]                        id_out,
	output logic                              accepted,
	output logic [4:0]                        neighbour_pos,
	output logic                              last
);
	import clbe_pkg::*;

	typedef enum logic [3:0] {
		S_CLR, S_IDLE, S_DIV, S_QDIV, S_NCHK, S_MUL1, S_MUL2, S_RDCNT, S_USE, S_EMIT
	} state_t;

	state_t state_q;
	logic [15:0] cell_size_q;
	logic [4:0]  side_cfg_q;
	logic        boot_q;
	logic [CELL_W-1:0] clr_cnt_q;
	func_t       func_q;
	logic [POS_W-1:0] pos_y_q, pos_z_q;
	logic [ID_W-1:0]  id_q;
	logic [CAP_W-1:0] slot_q;
	logic [1:0]  axis_q;
	logic [15:0] rem_q;
	logic [IDX_W-1:0] quo_q;
	logic [CELL_W-1:0] t_q;
	logic [4:0]  qrem_q;
	logic [3:0]  bit_cnt_q;
	logic [IDX_W-1:0] ctr_q [3];
	logic [IDX_W-1:0] k_q [3];
	logic [1:0]  dig_q [3];
	logic [CODE_W-1:0] code_q;
	logic [CELL_W-1:0] cell_q;
	// pending result
	logic [CELL_W-1:0] r_cell_q;
	logic [CNT_W-1:0]  r_cnt_q;
	logic [ID_W-1:0]   r_id_q;
	logic              r_acc_q;
	logic [CODE_W-1:0] r_pos_q;
	logic              r_last_q;
	// output register
	logic              ov_q;
	logic [CELL_W-1:0] o_cell_q;
	logic [CNT_W-1:0]  o_cnt_q;
	logic [ID_W-1:0]   o_id_q;
	logic              o_acc_q;
	logic [CODE_W-1:0] o_pos_q;
	logic              o_last_q;

	// memories
	logic [CNT_W-1:0] counts_mem [NUM_CELLS];
	logic [ID_W-1:0]  slots_mem [NUM_CELLS*CAP];
	logic [CNT_W-1:0] cnt_rd;
	logic [ID_W-1:0]  slot_rd;
	logic             cnt_we, slot_we;
	logic [CELL_W-1:0] cnt_waddr;
	logic [CNT_W-1:0]  cnt_wdata;

	logic [4:0]  side_w;
	logic [3:0]  side_m1;
	logic [15:0] size_w;
	logic        out_free;
	logic        wr_en;
	logic [5:0]  qtrial;
	logic signed [5:0] kn [3];
	logic        nb_ok;
	logic [1:0]  dmax [3];
	logic [CODE_W-1:0] last_code;
	logic [12:0] mul1, mul2;
	logic        cell_full;

	function automatic logic [15:0] offset_coord(input logic [POS_W-1:0] c);
		logic signed [POS_W:0] s;
		s = $signed({c[POS_W-1], c}) + $signed(ONE_FIXED);
		return s[POS_W] ? 16'd0 : s[15:0];
	endfunction

	always_comb begin
		if (side_cfg_q == 5'd0) side_w = 5'd1;
		else if (side_cfg_q > 5'(MAX_SIDE)) side_w = 5'(MAX_SIDE);
		else side_w = side_cfg_q;
	end
	assign side_m1  = 4'(side_w - 5'd1);
	assign size_w   = (cell_size_q == 16'd0) ? 16'd1 : cell_size_q;
	assign out_free = !ov_q || out_ready;
	assign qtrial   = {qrem_q, t_q[CELL_W-1]};
	assign cell_full = (cnt_rd >= 4'(CAP));

	always_comb begin
		nb_ok = 1'b1;
		for (int a = 0; a < 3; a++) begin
			kn[a] = $signed({2'b00, ctr_q[a]}) + $signed({4'b0000, dig_q[a]}) - 6'sd1;
			if (kn[a] < 0 || kn[a][4:0] >= side_w) nb_ok = 1'b0;
			dmax[a] = ({1'b0, ctr_q[a]} + 5'd1 < side_w) ? 2'd2 : 2'd1;
		end
		last_code = 5'(dmax[0]) + 5'(dmax[1]) * 5'd3 + 5'(dmax[2]) * 5'd9;
	end

	assign mul1 = 13'(k_q[2]) * 13'(side_w) + 13'(k_q[1]);
	assign mul2 = 13'(cell_q) * 13'(side_w) + 13'(k_q[0]);

	// APB
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	always_comb begin
		prdata = 32'd0;
		if (paddr[2] == REG_SIDE) prdata = {27'd0, side_cfg_q};
		else prdata = {16'd0, cell_size_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_size_q <= 16'd4096;
			side_cfg_q  <= 5'd16;
		end else if (wr_en) begin
			if (paddr[2] == REG_SIDE) side_cfg_q <= pwdata[4:0];
			else cell_size_q <= pwdata[15:0];
		end
	end

	// memory write selection
	always_comb begin
		cnt_we    = 1'b0;
		cnt_waddr = cell_q;
		cnt_wdata = 4'(cnt_rd + 4'd1);
		slot_we   = 1'b0;
		if (state_q == S_CLR) begin
			cnt_we    = 1'b1;
			cnt_waddr = clr_cnt_q;
			cnt_wdata = '0;
		end else if (state_q == S_USE && func_q == FN_INSERT && !cell_full) begin
			cnt_we  = 1'b1;
			slot_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cnt_we) counts_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd <= counts_mem[cell_q];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slots_mem[{cell_q, cnt_rd[CAP_W-1:0]}] <= id_q;
		slot_rd <= slots_mem[{cell_q, slot_q}];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLR;
			boot_q    <= 1'b1;
			clr_cnt_q <= '0;
			ov_q      <= 1'b0;
			func_q    <= FN_CLEAR;
			axis_q    <= '0;
			bit_cnt_q <= '0;
			code_q    <= '0;
		end else begin
			if (ov_q && out_ready) ov_q <= 1'b0;
			unique case (state_q)
				S_CLR: begin
					clr_cnt_q <= 12'(clr_cnt_q + 12'd1);
					if (clr_cnt_q == 12'(NUM_CELLS - 1)) begin
						clr_cnt_q <= '0;
						if (boot_q) begin
							boot_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							r_cell_q <= '0; r_cnt_q <= '0; r_id_q <= '0;
							r_acc_q  <= 1'b0; r_pos_q <= '0; r_last_q <= 1'b1;
							state_q  <= S_EMIT;
						end
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						func_q  <= func_t'(func);
						pos_y_q <= pos_y;
						pos_z_q <= pos_z;
						id_q    <= point_id;
						slot_q  <= slot_sel;
						axis_q  <= '0;
						quo_q   <= '0;
						rem_q   <= offset_coord(pos_x);
						t_q     <= cell_sel;
						qrem_q  <= '0;
						bit_cnt_q <= '0;
						cell_q  <= cell_sel;
						unique case (func_t'(func))
							FN_CLEAR:  state_q <= S_CLR;
							FN_INSERT: state_q <= S_DIV;
							FN_QUERY:  state_q <= S_QDIV;
							FN_READ:   state_q <= S_RDCNT;
						endcase
					end
				end
				S_DIV: begin
					// quotient by repeated subtraction, stops at side-1
					if (quo_q < side_m1 && rem_q >= size_w) begin
						rem_q <= rem_q - size_w;
						quo_q <= quo_q + 4'd1;
					end else begin
						k_q[axis_q] <= quo_q;
						quo_q <= '0;
						axis_q <= 2'(axis_q + 2'd1);
						if (axis_q == 2'd0) rem_q <= offset_coord(pos_y_q);
						else rem_q <= offset_coord(pos_z_q);
						if (axis_q == 2'd2) state_q <= S_MUL1;
					end
				end
				S_QDIV: begin
					// restoring division of t_q by side, one bit per cycle
					if (bit_cnt_q == 4'(CELL_W)) begin
						ctr_q[axis_q] <= qrem_q[IDX_W-1:0];
						qrem_q    <= '0;
						bit_cnt_q <= '0;
						axis_q    <= 2'(axis_q + 2'd1);
						if (axis_q == 2'd2) begin
							code_q  <= '0;
							dig_q[0] <= '0; dig_q[1] <= '0; dig_q[2] <= '0;
							state_q <= S_NCHK;
						end
					end else begin
						bit_cnt_q <= 4'(bit_cnt_q + 4'd1);
						if (qtrial >= 6'(side_w)) begin
							qrem_q <= 5'(qtrial - 6'(side_w));
							t_q    <= {t_q[CELL_W-2:0], 1'b1};
						end else begin
							qrem_q <= qtrial[4:0];
							t_q    <= {t_q[CELL_W-2:0], 1'b0};
						end
					end
				end
				S_NCHK: begin
					if (nb_ok) begin
						for (int a = 0; a < 3; a++) k_q[a] <= kn[a][IDX_W-1:0];
						state_q <= S_MUL1;
					end else begin
						code_q <= 5'(code_q + 5'd1);
						if (dig_q[0] != 2'd2) dig_q[0] <= 2'(dig_q[0] + 2'd1);
						else begin
							dig_q[0] <= '0;
							if (dig_q[1] != 2'd2) dig_q[1] <= 2'(dig_q[1] + 2'd1);
							else begin
								dig_q[1] <= '0;
								dig_q[2] <= 2'(dig_q[2] + 2'd1);
							end
						end
					end
				end
				S_MUL1: begin
					cell_q  <= mul1[CELL_W-1:0];
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					cell_q  <= mul2[CELL_W-1:0];
					state_q <= S_RDCNT;
				end
				S_RDCNT: state_q <= S_USE;
				S_USE: begin
					r_cell_q <= cell_q;
					r_acc_q  <= 1'b0;
					r_pos_q  <= '0;
					r_last_q <= 1'b1;
					r_cnt_q  <= cnt_rd;
					r_id_q   <= '0;
					priority if (func_q == FN_INSERT) begin
						r_id_q <= id_q;
						if (!cell_full) begin
							r_acc_q <= 1'b1;
							r_cnt_q <= 4'(cnt_rd + 4'd1);
						end
					end else if (func_q == FN_QUERY) begin
						r_pos_q  <= code_q;
						r_last_q <= (code_q == last_code);
					end else begin
						if (4'(slot_q) < cnt_rd) r_id_q <= slot_rd;
					end
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						ov_q     <= 1'b1;
						o_cell_q <= r_cell_q;
						o_cnt_q  <= r_cnt_q;
						o_id_q   <= r_id_q;
						o_acc_q  <= r_acc_q;
						o_pos_q  <= r_pos_q;
						o_last_q <= r_last_q;
						if (r_last_q) state_q <= S_IDLE;
						else begin
							code_q <= 5'(code_q + 5'd1);
							if (dig_q[0] != 2'd2) dig_q[0] <= 2'(dig_q[0] + 2'd1);
							else begin
								dig_q[0] <= '0;
								if (dig_q[1] != 2'd2) dig_q[1] <= 2'(dig_q[1] + 2'd1);
								else begin
									dig_q[1] <= '0;
									dig_q[2] <= 2'(dig_q[2] + 2'd1);
								end
							end
							state_q <= S_NCHK;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == S_IDLE);
	assign out_valid     = ov_q;
	assign cell_out      = o_cell_q;
	assign count_out     = o_cnt_q;
	assign id_out        = o_id_q;
	assign accepted      = o_acc_q;
	assign neighbour_pos = o_pos_q;
	assign last          = o_last_q;
endmodule
`default_nettype wire

FILE: hw/rtl/clbe_checker.sv
// Port-level checks for cell_list_binning_engine_core.
// Bound to cell_list_binning_engine_core; no package dependency.
`default_nettype none
module clbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [11:0] cell_out,
	input wire logic [3:0]  count_out,
	input wire logic        accepted,
	input wire logic [4:0]  neighbour_pos,
	input wire logic        last
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(cell_out) && $stable(last))
		else $error("result changed while stalled");
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second command taken while busy");
	a_cnt_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count_out <= 4'd8)
		else $error("cell count above capacity");
	a_acc_form: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && accepted |-> count_out != 4'd0 && neighbour_pos == 5'd0 && last)
		else $error("stored insert with bad result fields");
endmodule

bind cell_list_binning_engine_core clbe_checker u_clbe_checker (.*);
`default_nettype wire
